// ===== src/dlfd_pkg.sv =====
package dlfd_pkg;

    localparam int BUFFER_BYTES_DEF = 32;
    localparam int MAX_PAGES_DEF    = 4;
    localparam int SLOT_COUNT       = 4;
    localparam int OUT_TDATA_W      = 104;

    // input selector codes (s_tuser)
    localparam logic [1:0] OP_BYTE     = 2'd0;
    localparam logic [1:0] OP_TICK     = 2'd1;
    localparam logic [1:0] OP_START    = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    // result kinds (m_tuser)
    localparam logic [3:0] KIND_OK        = 4'd0;
    localparam logic [3:0] KIND_ERROR     = 4'd1;
    localparam logic [3:0] KIND_TOUCH     = 4'd2;
    localparam logic [3:0] KIND_TOUCHXY   = 4'd3;
    localparam logic [3:0] KIND_TEXTCHAR  = 4'd4;
    localparam logic [3:0] KIND_TEXTEMPTY = 4'd5;
    localparam logic [3:0] KIND_NUMERIC   = 4'd6;
    localparam logic [3:0] KIND_SLEEP     = 4'd7;
    localparam logic [3:0] KIND_WAKE      = 4'd8;
    localparam logic [3:0] KIND_LEAVE     = 4'd9;
    localparam logic [3:0] KIND_ENTER     = 4'd10;
    localparam logic [3:0] KIND_BEGIN     = 4'd11;
    localparam logic [3:0] KIND_REFRESH   = 4'd12;
    localparam logic [3:0] KIND_REQPAGE   = 4'd13;

    // message command bytes
    localparam logic [7:0] TERM_BYTE  = 8'hFF;
    localparam logic [7:0] CMD_OK     = 8'h01;
    localparam logic [7:0] CMD_ERR_A  = 8'h00;
    localparam logic [7:0] CMD_ERR_B  = 8'h02;
    localparam logic [7:0] CMD_ERR_C  = 8'h03;
    localparam logic [7:0] CMD_ERR_D  = 8'h04;
    localparam logic [7:0] CMD_ERR_E  = 8'h1A;
    localparam logic [7:0] CMD_ERR_F  = 8'h1B;
    localparam logic [7:0] CMD_ERR_G  = 8'h1C;
    localparam logic [7:0] CMD_TOUCH  = 8'h65;
    localparam logic [7:0] CMD_PAGE   = 8'h66;
    localparam logic [7:0] CMD_XY_A   = 8'h67;
    localparam logic [7:0] CMD_XY_B   = 8'h68;
    localparam logic [7:0] CMD_TEXT   = 8'h70;
    localparam logic [7:0] CMD_NUM    = 8'h71;
    localparam logic [7:0] CMD_SLEEP  = 8'h86;
    localparam logic [7:0] CMD_WAKE   = 8'h87;

    // configuration register indexes
    localparam logic [2:0] REG_PAGE_COUNT = 3'd0;
    localparam logic [2:0] REG_PAGE_ID0   = 3'd1;
    localparam logic [2:0] REG_PAGE_ID1   = 3'd2;
    localparam logic [2:0] REG_PAGE_ID2   = 3'd3;
    localparam logic [2:0] REG_PAGE_ID3   = 3'd4;
    localparam logic [2:0] REG_TIMEOUT    = 3'd5;
    localparam logic [2:0] REG_REFRESH    = 3'd6;

    typedef struct packed {
        logic [3:0]  kind;
        logic [1:0]  slot;
        logic [7:0]  code;
        logic [7:0]  component;
        logic [7:0]  event_type;
        logic [15:0] x_pos;
        logic [15:0] y_pos;
        logic [31:0] number;
        logic [7:0]  text_char;
    } result_t;

endpackage

// ===== src/display_link_frame_decoder.sv =====
// Display-link frame decoder. Each input beat is a received byte, a time tick or a
// start event (s_tuser selects which); each output beat is one decoded event, and
// m_tlast marks the last event caused by an input beat. An input beat is taken while
// s_tready is high; the block then drops s_tready until all its events have been loaded
// into the output register, one event per cycle while m_tready keeps up, outside a text run.
// A page change gives up to three events, a touch up to four, a tick up to two. A text
// run is read back from the message store one byte at a time, and the input stays held
// until its last character has been loaded into the output register. Header
// bytes of a message are kept in flops as they arrive, so all other messages decode in
// the cycle of the third terminator byte. The store needs no clearing after reset.
module display_link_frame_decoder #(
    parameter int BUFFER_BYTES = dlfd_pkg::BUFFER_BYTES_DEF,
    parameter int MAX_PAGES    = dlfd_pkg::MAX_PAGES_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // rx_byte
    input  logic [1:0]                       s_tuser,   // op
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // page_slot[1:0], code[9:2], component[17:10], event_type[25:18], x_pos[41:26],
    // y_pos[57:42], number[89:58], text_char[97:90], zero fill[103:98]
    output logic [dlfd_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic [3:0]                       m_tuser,   // kind
    output logic                             m_tlast,
    input  logic                             cfg_we,
    input  logic [2:0]                       cfg_index,
    input  logic [15:0]                      cfg_data
);
    import dlfd_pkg::*;

    localparam int AW   = $clog2(BUFFER_BYTES);
    localparam int WPW  = $clog2(BUFFER_BYTES + 1);
    localparam int HDR  = 6;
    localparam logic [WPW-1:0] BUF_FULL = WPW'(BUFFER_BYTES);
    localparam logic [AW-1:0]  TEXT_MAX = AW'(BUFFER_BYTES - 4);
    localparam logic [2:0]     PAGE_LIM = 3'(MAX_PAGES);

    // pending event bits, emitted lowest first
    localparam int P_LEAVE   = 0;
    localparam int P_ENTER   = 1;
    localparam int P_BEGIN   = 2;
    localparam int P_MAIN    = 3;
    localparam int P_TEXT    = 4;
    localparam int P_REQ     = 5;
    localparam int P_REFRESH = 6;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EVENT = 5'b00010,
        S_FETCH = 5'b00100,
        S_GOT   = 5'b01000,
        S_FINAL = 5'b10000
    } state_t;

    function automatic result_t mk(input logic [3:0] kind, input logic [1:0] slot,
                                   input logic [7:0] code);
        result_t r;
        r      = '0;
        r.kind = kind;
        r.slot = slot;
        r.code = code;
        return r;
    endfunction

    // configuration
    logic [2:0]  page_count_reg;
    logic [7:0]  page_id_reg [SLOT_COUNT];
    logic [15:0] timeout_reg;
    logic [15:0] refresh_ticks_reg;

    // control and message state
    state_t                  state_reg, state_next;
    logic [6:0]              pend_reg, pend_next;
    logic [1:0]              leave_slot_reg, leave_slot_next;
    logic [1:0]              enter_slot_reg, enter_slot_next;
    logic [1:0]              begin_slot_reg, begin_slot_next;
    result_t                 main_reg, main_next;
    logic [AW-1:0]           txt_cnt_reg, txt_cnt_next;
    logic [AW-1:0]           txt_idx_reg, txt_idx_next;
    logic [7:0]              txt_cur_reg, txt_cur_next;
    logic                    have_cur_reg, have_cur_next;
    logic [WPW-1:0]          wp_reg, wp_next;
    logic [1:0]              trun_reg, trun_next;
    logic                    in_msg_reg, in_msg_next;
    logic [15:0]             idle_reg, idle_next;
    logic [15:0]             refcnt_reg, refcnt_next;
    logic [1:0]              cur_slot_reg, cur_slot_next;
    logic [SLOT_COUNT-1:0]   begun_reg, begun_next;
    logic [7:0]              hdr_reg [HDR];
    result_t                 out_reg, out_next;
    logic                    out_last_reg, out_last_next;
    logic                    out_valid_reg, out_valid_next;

    // message store
    logic [7:0]     mem [BUFFER_BYTES];
    logic [7:0]     rd_data_reg;
    logic           mem_we;
    logic [WPW-1:0] pos;
    logic [WPW-1:0] wp_new;
    logic [WPW-1:0] lenv;
    logic [1:0]     teff;
    logic [1:0]     trun_new;
    logic [15:0]    idle_inc;
    logic [15:0]    ref_inc;

    // page lookup
    logic [2:0] used;
    logic       hp;
    logic       found;
    logic [1:0] fslot;
    logic       cur_match;
    logic       goto_enter;
    logic       goto_leave;
    logic       goto_begin;

    logic       can_load;
    logic [6:0] sel;
    logic [6:0] rest;

    assign used      = (page_count_reg > PAGE_LIM) ? PAGE_LIM : page_count_reg;
    assign hp        = ({1'b0, cur_slot_reg} < used);
    assign cur_match = hp && (page_id_reg[cur_slot_reg] == hdr_reg[1]);

    // lowest registered slot whose id matches the page byte of the message
    always_comb
    begin
        found = 1'b0;
        fslot = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if ((3'(i) < used) && (page_id_reg[i] == hdr_reg[1]))
            begin
                found = 1'b1;
                fslot = 2'(i);
            end
        end
    end

    assign goto_enter = found && !(hp && (cur_slot_reg == fslot));
    assign goto_leave = goto_enter && hp;
    assign goto_begin = goto_enter && !begun_reg[fslot];

    assign s_tready = (state_reg == S_IDLE);
    assign can_load = !out_valid_reg || m_tready;
    assign sel      = pend_reg & (~pend_reg + 7'd1);
    assign rest     = pend_reg & ~sel;

    assign idle_inc = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
    assign ref_inc  = (refcnt_reg == 16'hFFFF) ? refcnt_reg : refcnt_reg + 16'd1;

    always_comb
    begin
        state_next      = state_reg;
        pend_next       = pend_reg;
        leave_slot_next = leave_slot_reg;
        enter_slot_next = enter_slot_reg;
        begin_slot_next = begin_slot_reg;
        main_next       = main_reg;
        txt_cnt_next    = txt_cnt_reg;
        txt_idx_next    = txt_idx_reg;
        txt_cur_next    = txt_cur_reg;
        have_cur_next   = have_cur_reg;
        wp_next         = wp_reg;
        trun_next       = trun_reg;
        in_msg_next     = in_msg_reg;
        idle_next       = idle_reg;
        refcnt_next     = refcnt_reg;
        cur_slot_next   = cur_slot_reg;
        begun_next      = begun_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        mem_we          = 1'b0;
        pos             = in_msg_reg ? wp_reg : '0;
        teff            = in_msg_reg ? trun_reg : 2'd0;
        wp_new          = pos + WPW'(1);
        lenv            = wp_new - WPW'(3);
        trun_new        = (s_tdata == TERM_BYTE) ? teff + 2'd1 : 2'd0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    pend_next = '0;
                    case (s_tuser)
                        OP_BYTE:
                        begin
                            idle_next = '0;
                            if (!in_msg_reg && (s_tdata == TERM_BYTE))
                            begin
                                trun_next = '0;
                            end
                            else if (pos >= BUF_FULL)
                            begin
                                // overflow: drop the message and this byte
                                in_msg_next = 1'b0;
                                wp_next     = '0;
                                trun_next   = '0;
                            end
                            else
                            begin
                                mem_we = 1'b1;
                                if (trun_new == 2'd3)
                                begin
                                    in_msg_next = 1'b0;
                                    wp_next     = '0;
                                    trun_next   = '0;
                                    txt_cnt_next = ((lenv - WPW'(1)) > WPW'(TEXT_MAX)) ?
                                                   TEXT_MAX : AW'(lenv - WPW'(1));
                                    if (lenv != '0)
                                    begin
                                        unique case (hdr_reg[0])
                                            CMD_OK:
                                            begin
                                                main_next         = mk(KIND_OK, cur_slot_reg,
                                                                       hdr_reg[0]);
                                                pend_next[P_MAIN] = hp;
                                            end
                                            CMD_ERR_A, CMD_ERR_B, CMD_ERR_C, CMD_ERR_D,
                                            CMD_ERR_E, CMD_ERR_F, CMD_ERR_G:
                                            begin
                                                main_next         = mk(KIND_ERROR, cur_slot_reg,
                                                                       hdr_reg[0]);
                                                pend_next[P_MAIN] = hp;
                                            end
                                            CMD_TOUCH:
                                            begin
                                                if (lenv >= WPW'(4))
                                                begin
                                                    if (!cur_match)
                                                    begin
                                                        pend_next[P_LEAVE] = goto_leave;
                                                        pend_next[P_ENTER] = goto_enter;
                                                        pend_next[P_BEGIN] = goto_begin;
                                                        leave_slot_next    = cur_slot_reg;
                                                        enter_slot_next    = fslot;
                                                        begin_slot_next    = fslot;
                                                        if (goto_enter)
                                                            cur_slot_next = fslot;
                                                        if (goto_begin)
                                                            begun_next[fslot] = 1'b1;
                                                    end
                                                    main_next = mk(KIND_TOUCH,
                                                                   cur_match ? cur_slot_reg : fslot,
                                                                   hdr_reg[0]);
                                                    main_next.component  = hdr_reg[2];
                                                    main_next.event_type = hdr_reg[3];
                                                    pend_next[P_MAIN]    = cur_match || found;
                                                end
                                            end
                                            CMD_PAGE:
                                            begin
                                                if (lenv >= WPW'(2))
                                                begin
                                                    pend_next[P_LEAVE] = goto_leave;
                                                    pend_next[P_ENTER] = goto_enter;
                                                    pend_next[P_BEGIN] = goto_begin;
                                                    leave_slot_next    = cur_slot_reg;
                                                    enter_slot_next    = fslot;
                                                    begin_slot_next    = fslot;
                                                    if (goto_enter)
                                                        cur_slot_next = fslot;
                                                    if (goto_begin)
                                                        begun_next[fslot] = 1'b1;
                                                end
                                            end
                                            CMD_XY_A, CMD_XY_B:
                                            begin
                                                main_next = mk(KIND_TOUCHXY, cur_slot_reg,
                                                               hdr_reg[0]);
                                                main_next.event_type = hdr_reg[5];
                                                main_next.x_pos      = {hdr_reg[1], hdr_reg[2]};
                                                main_next.y_pos      = {hdr_reg[3], hdr_reg[4]};
                                                pend_next[P_MAIN]    = hp && (lenv >= WPW'(6));
                                            end
                                            CMD_TEXT:
                                            begin
                                                pend_next[P_TEXT] = hp;
                                            end
                                            CMD_NUM:
                                            begin
                                                main_next = mk(KIND_NUMERIC, cur_slot_reg,
                                                               hdr_reg[0]);
                                                main_next.number = {hdr_reg[4], hdr_reg[3],
                                                                    hdr_reg[2], hdr_reg[1]};
                                                pend_next[P_MAIN] = hp && (lenv >= WPW'(5));
                                            end
                                            CMD_SLEEP:
                                            begin
                                                main_next         = mk(KIND_SLEEP, cur_slot_reg,
                                                                       hdr_reg[0]);
                                                pend_next[P_MAIN] = hp;
                                            end
                                            CMD_WAKE:
                                            begin
                                                main_next         = mk(KIND_WAKE, cur_slot_reg,
                                                                       hdr_reg[0]);
                                                pend_next[P_MAIN] = hp;
                                            end
                                            default:
                                            begin
                                            end
                                        endcase
                                    end
                                end
                                else
                                begin
                                    in_msg_next = 1'b1;
                                    wp_next     = wp_new;
                                    trun_next   = trun_new;
                                end
                            end
                        end
                        OP_TICK:
                        begin
                            idle_next   = idle_inc;
                            refcnt_next = ref_inc;
                            if (in_msg_reg && (idle_inc > timeout_reg))
                            begin
                                in_msg_next      = 1'b0;
                                wp_next          = '0;
                                trun_next        = '0;
                                pend_next[P_REQ] = 1'b1;
                            end
                            if (hp && (ref_inc > refresh_ticks_reg))
                            begin
                                pend_next[P_REFRESH] = 1'b1;
                                refcnt_next          = '0;
                            end
                        end
                        OP_START:
                        begin
                            if (hp && !begun_reg[cur_slot_reg])
                            begin
                                pend_next[P_BEGIN]       = 1'b1;
                                begin_slot_next          = cur_slot_reg;
                                begun_next[cur_slot_reg] = 1'b1;
                            end
                            pend_next[P_REQ] = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                    state_next = (pend_next != '0) ? S_EVENT : S_IDLE;
                end
            end

            S_EVENT:
            begin
                if (sel[P_TEXT])
                begin
                    // a text run is always the last thing a message yields
                    if (txt_cnt_reg == '0)
                    begin
                        if (can_load)
                        begin
                            out_next       = mk(KIND_TEXTEMPTY, cur_slot_reg, CMD_TEXT);
                            out_last_next  = 1'b1;
                            out_valid_next = 1'b1;
                            pend_next      = '0;
                            state_next     = S_IDLE;
                        end
                    end
                    else
                    begin
                        txt_idx_next  = AW'(1);
                        have_cur_next = 1'b0;
                        state_next    = S_FETCH;
                    end
                end
                else if (can_load)
                begin
                    priority if (sel[P_LEAVE])
                        out_next = mk(KIND_LEAVE, leave_slot_reg, 8'h00);
                    else if (sel[P_ENTER])
                        out_next = mk(KIND_ENTER, enter_slot_reg, 8'h00);
                    else if (sel[P_BEGIN])
                        out_next = mk(KIND_BEGIN, begin_slot_reg, 8'h00);
                    else if (sel[P_MAIN])
                        out_next = main_reg;
                    else if (sel[P_REQ])
                        out_next = mk(KIND_REQPAGE, 2'd0, 8'h00);
                    else
                        out_next = mk(KIND_REFRESH, cur_slot_reg, 8'h00);
                    out_last_next  = (rest == '0);
                    out_valid_next = 1'b1;
                    pend_next      = rest;
                    if (rest == '0)
                        state_next = S_IDLE;
                end
            end

            S_FETCH:
            begin
                state_next = S_GOT;
            end

            S_GOT:
            begin
                // rd_data_reg holds the byte at txt_idx_reg
                if (!have_cur_reg)
                begin
                    if (rd_data_reg == 8'h00)
                    begin
                        if (can_load)
                        begin
                            out_next       = mk(KIND_TEXTEMPTY, cur_slot_reg, CMD_TEXT);
                            out_last_next  = 1'b1;
                            out_valid_next = 1'b1;
                            pend_next      = '0;
                            state_next     = S_IDLE;
                        end
                    end
                    else
                    begin
                        txt_cur_next  = rd_data_reg;
                        have_cur_next = 1'b1;
                        if (txt_idx_reg == txt_cnt_reg)
                            state_next = S_FINAL;
                        else
                        begin
                            txt_idx_next = txt_idx_reg + AW'(1);
                            state_next   = S_FETCH;
                        end
                    end
                end
                else if (can_load)
                begin
                    out_next           = mk(KIND_TEXTCHAR, cur_slot_reg, CMD_TEXT);
                    out_next.text_char = txt_cur_reg;
                    out_last_next      = (rd_data_reg == 8'h00);
                    out_valid_next     = 1'b1;
                    if (rd_data_reg == 8'h00)
                    begin
                        pend_next  = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        txt_cur_next = rd_data_reg;
                        if (txt_idx_reg == txt_cnt_reg)
                            state_next = S_FINAL;
                        else
                        begin
                            txt_idx_next = txt_idx_reg + AW'(1);
                            state_next   = S_FETCH;
                        end
                    end
                end
            end

            S_FINAL:
            begin
                if (can_load)
                begin
                    out_next           = mk(KIND_TEXTCHAR, cur_slot_reg, CMD_TEXT);
                    out_next.text_char = txt_cur_reg;
                    out_last_next      = 1'b1;
                    out_valid_next     = 1'b1;
                    pend_next          = '0;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_count_reg    <= 3'd0;
            page_id_reg[0]    <= 8'd0;
            page_id_reg[1]    <= 8'd1;
            page_id_reg[2]    <= 8'd2;
            page_id_reg[3]    <= 8'd3;
            timeout_reg       <= 16'd100;
            refresh_ticks_reg <= 16'd1000;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PAGE_COUNT: page_count_reg    <= cfg_data[2:0];
                REG_PAGE_ID0:   page_id_reg[0]    <= cfg_data[7:0];
                REG_PAGE_ID1:   page_id_reg[1]    <= cfg_data[7:0];
                REG_PAGE_ID2:   page_id_reg[2]    <= cfg_data[7:0];
                REG_PAGE_ID3:   page_id_reg[3]    <= cfg_data[7:0];
                REG_TIMEOUT:    timeout_reg       <= cfg_data;
                REG_REFRESH:    refresh_ticks_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= '0;
            have_cur_reg  <= 1'b0;
            wp_reg        <= '0;
            trun_reg      <= '0;
            in_msg_reg    <= 1'b0;
            idle_reg      <= '0;
            refcnt_reg    <= '0;
            cur_slot_reg  <= '0;
            begun_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            have_cur_reg  <= have_cur_next;
            wp_reg        <= wp_next;
            trun_reg      <= trun_next;
            in_msg_reg    <= in_msg_next;
            idle_reg      <= idle_next;
            refcnt_reg    <= refcnt_next;
            cur_slot_reg  <= cur_slot_next;
            begun_reg     <= begun_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, header copy and message store
    always_ff @(posedge clk)
    begin
        leave_slot_reg <= leave_slot_next;
        enter_slot_reg <= enter_slot_next;
        begin_slot_reg <= begin_slot_next;
        main_reg       <= main_next;
        txt_cnt_reg    <= txt_cnt_next;
        txt_idx_reg    <= txt_idx_next;
        txt_cur_reg    <= txt_cur_next;
        out_reg        <= out_next;
        out_last_reg   <= out_last_next;
        for (int i = 0; i < HDR; i++)
        begin
            if (mem_we && (pos == WPW'(i)))
                hdr_reg[i] <= s_tdata;
        end
        if (mem_we)
            mem[pos[AW-1:0]] <= s_tdata;
        rd_data_reg <= mem[txt_idx_reg];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {6'b0, out_reg.text_char, out_reg.number, out_reg.y_pos, out_reg.x_pos,
                       out_reg.event_type, out_reg.component, out_reg.code, out_reg.slot};

endmodule

// ===== src/dlfd_checker.sv =====
module dlfd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic [7:0]                       s_tdata,
    input logic [1:0]                       s_tuser,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [dlfd_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic [3:0]                       m_tuser,
    input logic                             m_tlast,
    input logic                             cfg_we,
    input logic [2:0]                       cfg_index,
    input logic [15:0]                      cfg_data
);
    import dlfd_pkg::*;

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // a start beat always yields results, so the input side must close
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == OP_START) |=> !s_tready)
        else $error("start beat did not occupy the decoder");

    // page request carries slot 0 and no code
    a_req_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_REQPAGE) |-> (m_tdata[9:0] == 10'd0))
        else $error("page request with nonzero slot or code");

    // page-flow events carry no code byte
    a_page_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tuser == KIND_LEAVE) || (m_tuser == KIND_ENTER) ||
                     (m_tuser == KIND_BEGIN) || (m_tuser == KIND_REFRESH))
        |-> (m_tdata[9:2] == 8'd0))
        else $error("page event with nonzero code");

endmodule

bind display_link_frame_decoder dlfd_checker u_dlfd_checker (.*);
